/* src/pit_pkg.sv */
`default_nettype none
package pit_pkg;

    localparam int TOL_W        = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

    localparam int OUT_BITS     = 9;
    localparam int OUT_DATA_W   = 16;

    localparam logic [1:0] CODE_UP   = 2'd0;
    localparam logic [1:0] CODE_DOWN = 2'd1;
    localparam logic [1:0] CODE_ON   = 2'd2;
    localparam logic [1:0] CODE_NONE = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

endpackage
`default_nettype wire

/* src/pit_project.sv */
`default_nettype none
module pit_project
    import pit_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] pt [3],
    input  logic signed [W-1:0] ca [3],
    input  logic signed [W-1:0] cb [3],
    input  logic signed [W-1:0] cc [3],
    output logic [1:0]          axis,
    output logic signed [W-1:0] pu,
    output logic signed [W-1:0] pv,
    output logic signed [W-1:0] u [3],
    output logic signed [W-1:0] v [3]
);

    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 3;

    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [W-1:0]  p1_reg [3];
    logic signed [W-1:0]  c1_reg [3][3];

    logic signed [PW-1:0] m2_reg [6];
    logic signed [W-1:0]  p2_reg [3];
    logic signed [W-1:0]  c2_reg [3][3];

    logic [NW-1:0]        n3_reg [3];
    logic signed [W-1:0]  p3_reg [3];
    logic signed [W-1:0]  c3_reg [3][3];

    logic [1:0]           axis_reg;
    logic signed [W-1:0]  pu_reg;
    logic signed [W-1:0]  pv_reg;
    logic signed [W-1:0]  u_reg [3];
    logic signed [W-1:0]  v_reg [3];

    logic signed [NW-1:0] ndiff [3];
    logic [NW-1:0]        best;
    logic                 gt1;
    logic                 gt2;
    logic [1:0]           axis_next;
    logic [1:0]           ui;
    logic [1:0]           vi;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ndiff[i] = NW'(m2_reg[2*i]) - NW'(m2_reg[2*i+1]);
        end
    end

    always_comb begin
        gt1 = n3_reg[1] > n3_reg[0];
        best = gt1 ? n3_reg[1] : n3_reg[0];
        gt2 = n3_reg[2] > best;
        axis_next = gt2 ? AXIS_Z : (gt1 ? AXIS_Y : AXIS_X);
        case (axis_next)
            AXIS_X: begin
                ui = 2'd1;
                vi = 2'd2;
            end
            AXIS_Y: begin
                ui = 2'd0;
                vi = 2'd2;
            end
            AXIS_Z: begin
                ui = 2'd0;
                vi = 2'd1;
            end
            default: begin
                ui = 2'd0;
                vi = 2'd1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]    <= DW'(cb[i]) - DW'(ca[i]);
                e1_reg[i]    <= DW'(cc[i]) - DW'(ca[i]);
                p1_reg[i]    <= pt[i];
                c1_reg[0][i] <= ca[i];
                c1_reg[1][i] <= cb[i];
                c1_reg[2][i] <= cc[i];
            end

            m2_reg[0] <= PW'(d1_reg[1]) * PW'(e1_reg[2]);
            m2_reg[1] <= PW'(d1_reg[2]) * PW'(e1_reg[1]);
            m2_reg[2] <= PW'(d1_reg[2]) * PW'(e1_reg[0]);
            m2_reg[3] <= PW'(d1_reg[0]) * PW'(e1_reg[2]);
            m2_reg[4] <= PW'(d1_reg[0]) * PW'(e1_reg[1]);
            m2_reg[5] <= PW'(d1_reg[1]) * PW'(e1_reg[0]);
            p2_reg <= p1_reg;
            c2_reg <= c1_reg;

            for (int i = 0; i < 3; i++) begin
                n3_reg[i] <= ndiff[i][NW-1] ? NW'(-ndiff[i]) : NW'(ndiff[i]);
            end
            p3_reg <= p2_reg;
            c3_reg <= c2_reg;

            axis_reg <= axis_next;
            pu_reg   <= p3_reg[ui];
            pv_reg   <= p3_reg[vi];
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= c3_reg[k][ui];
                v_reg[k] <= c3_reg[k][vi];
            end
        end
    end

    assign axis = axis_reg;
    assign pu   = pu_reg;
    assign pv   = pv_reg;
    assign u    = u_reg;
    assign v    = v_reg;

endmodule
`default_nettype wire

/* src/pit_div.sv */
`default_nettype none
module pit_div #(
    parameter int NW = 65,
    parameter int DW = 33,
    parameter int SW = 66
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [NW-1:0]       num,
    input  logic [DW-1:0]       den,
    input  logic [SW-1:0]       side_in,
    output logic [NW-DW:0]      quo,
    output logic [SW-1:0]       side_out
);

    localparam int QW = NW - DW + 1;
    localparam int RW = DW - 1;

    logic [RW-1:0] r_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic [QW-1:0] n_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [SW-1:0] s_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [RW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [QW-1:0] n_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW-1:0] rr;
        logic [DW-1:0] diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign r_in = num[NW-1:QW];
            assign q_in = '0;
            assign n_in = num[QW-1:0];
            assign d_in = den;
            assign s_in = side_in;
        end else begin : g_next
            assign r_in = r_reg[s-1];
            assign q_in = q_reg[s-1];
            assign n_in = n_reg[s-1];
            assign d_in = d_reg[s-1];
            assign s_in = s_reg[s-1];
        end

        always_comb begin
            rr   = {r_in, n_in[QW-1-s]};
            diff = rr - d_in;
            ge   = rr >= d_in;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s] <= ge ? diff[RW-1:0] : rr[RW-1:0];
                q_reg[s] <= q_in | (QW'(ge) << (QW-1-s));
                n_reg[s] <= n_in;
                d_reg[s] <= d_in;
                s_reg[s] <= s_in;
            end
        end
    end

    assign quo      = q_reg[QW-1];
    assign side_out = s_reg[QW-1];

endmodule
`default_nettype wire

/* src/pit_edge.sv */
`default_nettype none
module pit_edge
    import pit_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [TOL_W-1:0]    tol,
    input  logic signed [W-1:0] pu,
    input  logic signed [W-1:0] pv,
    input  logic signed [W-1:0] u1,
    input  logic signed [W-1:0] v1,
    input  logic signed [W-1:0] u2,
    input  logic signed [W-1:0] v2,
    output logic [1:0]          code
);

    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 1;
    localparam int VW = W + 2;
    localparam int SW = 2 * W + 2;

    logic signed [DW-1:0] du1_reg;
    logic signed [DW-1:0] dv1_reg;
    logic signed [DW-1:0] dp1_reg;
    logic                 btw1_reg;
    logic signed [W-1:0]  v1_1_reg;
    logic signed [W-1:0]  pv1_reg;

    logic [DW-1:0]        dum2_reg;
    logic                 dun2_reg;
    logic                 none2_reg;
    logic signed [PW-1:0] prod2_reg;
    logic signed [W-1:0]  v1_2_reg;
    logic signed [W-1:0]  pv2_reg;

    logic [NW-1:0]        nm3_reg;
    logic [DW-1:0]        dum3_reg;
    logic                 neg3_reg;
    logic                 none3_reg;
    logic signed [W-1:0]  v1_3_reg;
    logic signed [W-1:0]  pv3_reg;

    logic signed [VW-1:0] val4_reg;
    logic signed [VW-1:0] hi4_reg;
    logic signed [VW-1:0] lo4_reg;
    logic                 none4_reg;

    logic [1:0]           code_reg;

    logic [DW-1:0]        dum;
    logic [DW-1:0]        tol_d;
    logic [DW-1:0]        quo;
    logic [SW-1:0]        side_out;
    logic                 neg_q;
    logic                 none_q;
    logic signed [W-1:0]  v1_q;
    logic signed [W-1:0]  pv_q;
    logic signed [VW-1:0] q_s;
    logic signed [VW-1:0] tol_s;

    always_comb begin
        dum   = du1_reg[DW-1] ? DW'(-du1_reg) : DW'(du1_reg);
        tol_d = DW'(tol);
        tol_s = $signed(VW'(tol));
        q_s   = $signed(VW'(quo));
        {none_q, neg_q, v1_q, pv_q} = side_out;
    end

    pit_div #(
        .NW (NW),
        .DW (DW),
        .SW (SW)
    ) u_div (
        .aclk     (aclk),
        .en       (en),
        .num      (nm3_reg),
        .den      (dum3_reg),
        .side_in  ({none3_reg, neg3_reg, v1_3_reg, pv3_reg}),
        .quo      (quo),
        .side_out (side_out)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            du1_reg  <= DW'(u2) - DW'(u1);
            dv1_reg  <= DW'(v2) - DW'(v1);
            dp1_reg  <= DW'(pu) - DW'(u1);
            btw1_reg <= ((pu >= u1) && (pu <= u2)) || ((pu <= u1) && (pu >= u2));
            v1_1_reg <= v1;
            pv1_reg  <= pv;

            dum2_reg  <= dum;
            dun2_reg  <= du1_reg[DW-1];
            none2_reg <= (dum <= tol_d) || !btw1_reg;
            prod2_reg <= PW'(dv1_reg) * PW'(dp1_reg);
            v1_2_reg  <= v1_1_reg;
            pv2_reg   <= pv1_reg;

            nm3_reg   <= prod2_reg[PW-1] ? NW'(-prod2_reg) : NW'(prod2_reg);
            neg3_reg  <= prod2_reg[PW-1] ^ dun2_reg;
            dum3_reg  <= dum2_reg;
            none3_reg <= none2_reg;
            v1_3_reg  <= v1_2_reg;
            pv3_reg   <= pv2_reg;

            val4_reg  <= neg_q ? VW'(v1_q) - q_s : VW'(v1_q) + q_s;
            hi4_reg   <= VW'(pv_q) + tol_s;
            lo4_reg   <= VW'(pv_q) - tol_s;
            none4_reg <= none_q;

            if (none4_reg) begin
                code_reg <= CODE_NONE;
            end else if (val4_reg > hi4_reg) begin
                code_reg <= CODE_UP;
            end else if (val4_reg < lo4_reg) begin
                code_reg <= CODE_DOWN;
            end else begin
                code_reg <= CODE_ON;
            end
        end
    end

    assign code = code_reg;

endmodule
`default_nettype wire

/* src/point_in_triangle_test.sv */
// Throughput: one item per cycle; the edge dividers retire one quotient bit per stage.
// The whole pipeline holds while a result waits and m_tready is low.
// Reset (aresetn low, synchronous): pipeline emptied, tolerance back to 16.
`default_nettype none
module point_in_triangle_test
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [TOL_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, point_z, corner_a_x..z, corner_b_x..z, corner_c_x..z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // contains, drop_axis, edge_ab_code, edge_bc_code, edge_ca_code
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    localparam int W     = COORD_WIDTH;
    localparam int E_LAT = W + 6;
    localparam int LAT   = 4 + E_LAT;

    logic [TOL_W-1:0]      tol_reg;
    logic [LAT-1:0]        vld_reg;
    logic [LAT-1:0]        vld_next;
    logic [1:0]            ax_reg [E_LAT];
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  en;

    logic signed [W-1:0]   pt [3];
    logic signed [W-1:0]   ca [3];
    logic signed [W-1:0]   cb [3];
    logic signed [W-1:0]   cc [3];
    logic [1:0]            axis;
    logic signed [W-1:0]   pu;
    logic signed [W-1:0]   pv;
    logic signed [W-1:0]   u [3];
    logic signed [W-1:0]   v [3];
    logic [1:0]            code [3];
    logic                  up;
    logic                  down;
    logic                  on;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i] = s_tdata[i*W +: W];
            ca[i] = s_tdata[(3+i)*W +: W];
            cb[i] = s_tdata[(6+i)*W +: W];
            cc[i] = s_tdata[(9+i)*W +: W];
        end
    end

    pit_project #(
        .W (W)
    ) u_project (
        .aclk (aclk),
        .en   (en),
        .pt   (pt),
        .ca   (ca),
        .cb   (cb),
        .cc   (cc),
        .axis (axis),
        .pu   (pu),
        .pv   (pv),
        .u    (u),
        .v    (v)
    );

    for (genvar k = 0; k < 3; k++) begin : g_edge
        pit_edge #(
            .W (W)
        ) u_edge (
            .aclk (aclk),
            .en   (en),
            .tol  (tol_reg),
            .pu   (pu),
            .pv   (pv),
            .u1   (u[k]),
            .v1   (v[k]),
            .u2   (u[(k+1)%3]),
            .v2   (v[(k+1)%3]),
            .code (code[k])
        );
    end

    always_comb begin
        up   = 1'b0;
        down = 1'b0;
        on   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            up   = up   || (code[k] == CODE_UP);
            down = down || (code[k] == CODE_DOWN);
            on   = on   || (code[k] == CODE_ON);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg      <= TOL_RESET;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            if (en) begin
                vld_reg      <= vld_next;
                m_tvalid_reg <= vld_reg[LAT-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg[0] <= axis;
            for (int i = 1; i < E_LAT; i++) begin
                ax_reg[i] <= ax_reg[i-1];
            end
            m_tdata_reg <= OUT_DATA_W'({code[2], code[1], code[0], ax_reg[E_LAT-1],
                                        (up && down) || on});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* sim/tb_point_in_triangle_test.sv */
`default_nettype none
module tb_point_in_triangle_test;
    import pit_pkg::*;

    localparam int CW = 32;
    localparam int IN_W = ((12*CW+7)/8)*8;
    localparam int LATENCY = CW + 11;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [CW-1:0] crd [12];
    } tri_query_t;

    typedef struct {
        logic       contains;
        logic [1:0] drop_axis;
        logic [1:0] ab;
        logic [1:0] bc;
        logic [1:0] ca;
    } hit_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [TOL_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    tri_query_t pending_q [$];
    hit_t       expected_hits [$];
    logic [TOL_W-1:0] tol_shadow = TOL_RESET;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  driving_done = 1'b0;

    point_in_triangle_test #(.COORD_WIDTH(CW)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [1:0] edge_code(logic signed [CW-1:0] pu, logic signed [CW-1:0] pv,
                                             logic signed [CW-1:0] u1, logic signed [CW-1:0] v1,
                                             logic signed [CW-1:0] u2, logic signed [CW-1:0] v2,
                                             logic [TOL_W-1:0] tol);
        logic signed [CW+1:0]  du;
        logic signed [CW+1:0]  mdu;
        logic signed [2*CW+3:0] num;
        logic signed [2*CW+3:0] q;
        logic signed [CW+3:0]  tl;
        logic signed [2*CW+3:0] val;
        du = u2 - u1;
        mdu = du < 0 ? -du : du;
        tl = tol;
        if (mdu <= tl)
            return CODE_NONE;
        if (!((pu >= u1 && pu <= u2) || (pu <= u1 && pu >= u2)))
            return CODE_NONE;
        num = (v2 - v1) * (pu - u1);
        q = num / du;
        val = v1 + q;
        if (val > pv + tl)
            return CODE_UP;
        if (val < pv - tl)
            return CODE_DOWN;
        return CODE_ON;
    endfunction

    function automatic hit_t locate_point(tri_query_t t, logic [TOL_W-1:0] tol);
        logic signed [CW:0]     d [3];
        logic signed [CW:0]     e [3];
        logic signed [2*CW+3:0] n [3];
        logic signed [2*CW+3:0] best;
        logic [1:0] codes [3];
        int ui, vi, k, j;
        bit up, down, on;
        hit_t h;
        for (int i = 0; i < 3; i++) begin
            d[i] = t.crd[6+i] - t.crd[3+i];
            e[i] = t.crd[9+i] - t.crd[3+i];
        end
        n[0] = d[1]*e[2] - d[2]*e[1];
        n[1] = d[2]*e[0] - d[0]*e[2];
        n[2] = d[0]*e[1] - d[1]*e[0];
        for (int i = 0; i < 3; i++)
            if (n[i] < 0) n[i] = -n[i];
        h.drop_axis = AXIS_X;
        best = n[0];
        if (n[1] > best) begin
            h.drop_axis = AXIS_Y;
            best = n[1];
        end
        if (n[2] > best)
            h.drop_axis = AXIS_Z;
        ui = h.drop_axis == AXIS_X ? 1 : 0;
        vi = h.drop_axis == AXIS_Z ? 1 : 2;
        up = 0; down = 0; on = 0;
        for (k = 0; k < 3; k++) begin
            j = (k + 1) % 3;
            codes[k] = edge_code(t.crd[ui], t.crd[vi], t.crd[3+3*k+ui], t.crd[3+3*k+vi],
                                 t.crd[3+3*j+ui], t.crd[3+3*j+vi], tol);
            if (codes[k] == CODE_UP) up = 1;
            else if (codes[k] == CODE_DOWN) down = 1;
            else if (codes[k] == CODE_ON) on = 1;
        end
        h.contains = (up && down) || on;
        h.ab = codes[0];
        h.bc = codes[1];
        h.ca = codes[2];
        return h;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 20)) - 10 <<< 16;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic tri_query_t rand_query();
        tri_query_t t;
        int style;
        int w;
        style = $urandom_range(0, 9);
        style = style < 2 ? 0 : (style < 6 ? 1 : (style < 9 ? 2 : 3));
        for (int i = 0; i < 12; i++)
            t.crd[i] = $urandom_range(0, 15) == 0 ? rand_coord(3) : rand_coord(style);
        if ($urandom_range(0, 3) != 0) begin
            // place the point at or near corner a, or at a scaled blend of the corners
            w = $urandom_range(0, 4);
            for (int i = 0; i < 3; i++) begin
                case (w)
                    0: t.crd[i] = t.crd[3+i];
                    1: t.crd[i] = (t.crd[3+i] >>> 1) + (t.crd[6+i] >>> 1);
                    2: t.crd[i] = (t.crd[3+i] >>> 2) + (t.crd[6+i] >>> 2) + (t.crd[9+i] >>> 1);
                    3: t.crd[i] = (t.crd[3+i] >>> 2) + (t.crd[6+i] >>> 2) + (t.crd[9+i] >>> 2);
                    default: t.crd[i] = t.crd[3+i] + $signed($urandom_range(0, 64)) - 32;
                endcase
            end
        end
        return t;
    endfunction

    function automatic tri_query_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                              int bx, int by, int bz, int cx, int cy, int cz);
        tri_query_t t;
        t.crd = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    task automatic drain();
        wait (pending_q.size() == 0 && !s_tvalid && expected_hits.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tol_shadow = v;
        @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_q.push_back(rand_query());
    endtask

    // driver
    always @(posedge aclk) begin
        logic [IN_W-1:0] next_word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_hits.push_back(locate_point(pending_q.pop_front(), tol_shadow));
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_word = '0;
                for (int i = 0; i < 12; i++)
                    next_word[i*CW +: CW] = pending_q[0].crd[i];
                s_tvalid <= 1'b1;
                s_tdata <= next_word;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        hit_t exp_h;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    exp_h = expected_hits.pop_front();
                    if (m_tdata[0] !== exp_h.contains) begin
                        $error("contains exp %0d got %0d", exp_h.contains, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[2:1] !== exp_h.drop_axis) begin
                        $error("drop_axis exp %0d got %0d", exp_h.drop_axis, m_tdata[2:1]);
                        errors++;
                    end
                    if (m_tdata[4:3] !== exp_h.ab) begin
                        $error("edge_ab_code exp %0d got %0d", exp_h.ab, m_tdata[4:3]);
                        errors++;
                    end
                    if (m_tdata[6:5] !== exp_h.bc) begin
                        $error("edge_bc_code exp %0d got %0d", exp_h.bc, m_tdata[6:5]);
                        errors++;
                    end
                    if (m_tdata[8:7] !== exp_h.ca) begin
                        $error("edge_ca_code exp %0d got %0d", exp_h.ca, m_tdata[8:7]);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || driving_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: reset tolerance first
        pending_q.push_back(make_query(1<<16, 1<<16, 0, 0, 0, 0, 4<<16, 0, 0, 0, 4<<16, 0));
        pending_q.push_back(make_query(9<<16, 9<<16, 0, 0, 0, 0, 4<<16, 0, 0, 0, 4<<16, 0));
        pending_q.push_back(make_query(2<<16, 0, 0, 0, 0, 0, 4<<16, 0, 0, 0, 4<<16, 0));
        pending_q.push_back(make_query(0, 1<<16, 1<<16, 0, 0, 0, 0, 4<<16, 0, 0, 0, 4<<16));
        pending_q.push_back(make_query(1<<16, 0, 1<<16, 0, 0, 0, 4<<16, 0, 0, 0, 0, 4<<16));
        pending_q.push_back(make_query(5, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_query(1, 1, 1, 0, 0, 0, 10, 10, 10, 20, 20, 20));
        pending_q.push_back(make_query(0, 0, 0, 0, 0, 0, 8, 8, 0, 8, 0, 8));
        pending_q.push_back(make_query(0, 0, 0, mn, mn, mn, mx, mx, mx, mx, mn, 0));
        pending_q.push_back(make_query(mx, mx, mx, mn, mn, 0, mx, mn, mn, mn, mx, mx));
        pending_q.push_back(make_query(mn, mn, mn, mn, mx, mn, mx, mn, mx, 0, 0, mn));
        pending_q.push_back(make_query(-1, -1, -1, mx, mx, mx, mn, mn, mn, mx, mn, mx));
        pending_q.push_back(make_query(3, 20, 0, 0, 0, 0, 10, 0, 0, 0, 40, 0));
        pending_q.push_back(make_query(0, 0, 0, 0, 0, 0, 10, 0, 0, 20, 0, 0));
        drain();
        write_tolerance('0);
        pending_q.push_back(make_query(2, 2, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
        pending_q.push_back(make_query(1, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_q.push_back(make_query(3, 1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
        queue_random(180);
        drain();
        write_tolerance(16'hffff);
        pending_q.push_back(make_query(1<<16, 1<<16, 0, 0, 0, 0, 4<<16, 0, 0, 0, 4<<16, 0));
        send_idle_pct = 78;
        queue_random(150);
        drain();
        write_tolerance(16'd100);
        send_idle_pct = 0;
        recv_stall_pct = 78;
        queue_random(150);
        drain();
        write_tolerance($urandom_range(0, 65535));
        send_idle_pct = 37;
        recv_stall_pct = 37;
        queue_random(150);
        drain();
        write_tolerance(TOL_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 300;
        queue_random(150);
        drain();
        driving_done = 1'b1;
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
src/pit_pkg.sv
src/pit_project.sv
src/pit_div.sv
src/pit_edge.sv
src/point_in_triangle_test.sv
sim/tb_point_in_triangle_test.sv
